@@ rtl/core/mstw_pkg.sv @@
// mstw_pkg: shared types and constants for the spanning tree weight block.
// No dependencies.
`default_nettype none
package mstw_pkg;
  localparam int MAX_VERTICES_DEF = 64;
  localparam int MAX_EDGES_DEF    = 256;
  localparam int WEIGHT_BITS_DEF  = 16;
  localparam int VTX_W            = 7;
  localparam int TOTAL_W          = 22;

  typedef struct packed {
    logic [VTX_W-1:0]  edge_from;
    logic [VTX_W-1:0]  edge_to;
    logic signed [15:0] edge_weight;
    logic              last_edge;
  } in_item_t;

  typedef struct packed {
    logic signed [TOTAL_W-1:0] total_weight;
    logic                      disconnected;
    logic                      edges_dropped;
  } out_item_t;

  // Job handed from the front part to the back part.
  typedef struct packed {
    logic [16:0] fill;
    logic        dropped;
  } job_t;
endpackage
`default_nettype wire

@@ rtl/core/mstw_ram.sv @@
// mstw_ram: generic single-port-write, one-read RAM with registered read.
// No dependencies.
`default_nettype none
module mstw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]              rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

@@ rtl/core/mstw_front.sv @@
// mstw_front: accepts edges, writes them to the store, queues a job on the last edge.
// Depends on mstw_pkg.
`default_nettype none
module mstw_front #(
  parameter int MAX_EDGES = mstw_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = mstw_pkg::WEIGHT_BITS_DEF,
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                take,
  input  wire mstw_pkg::in_item_t  item,
  output logic                     we,
  output logic [AW-1:0]            waddr,
  output logic [2*mstw_pkg::VTX_W+WEIGHT_BITS-1:0] wdata,
  output logic                     job_push,
  output mstw_pkg::job_t           job
);
  logic [16:0] fill_r, fill_nxt;
  logic        ovf_r, ovf_nxt;
  logic        room;
  logic [WEIGHT_BITS-1:0] w;

  assign room  = fill_r < 17'(MAX_EDGES);
  assign w     = WEIGHT_BITS'(item.edge_weight);
  assign we    = take && room;
  assign waddr = fill_r[AW-1:0];
  assign wdata = {item.edge_from, item.edge_to, w};
  assign job_push    = take && item.last_edge;
  assign job.fill    = we ? fill_r + 17'd1 : fill_r;
  assign job.dropped = ovf_r || (take && !room);

  always_comb begin
    fill_nxt = fill_r;
    ovf_nxt  = ovf_r;
    if (take) begin
      if (item.last_edge) begin
        fill_nxt = '0;
        ovf_nxt  = 1'b0;
      end else if (room) begin
        fill_nxt = fill_r + 17'd1;
      end else begin
        ovf_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r <= '0;
      ovf_r  <= 1'b0;
    end else begin
      fill_r <= fill_nxt;
      ovf_r  <= ovf_nxt;
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/mstw_back.sv @@
// mstw_back: Prim rounds over the edge store, one edge read per cycle.
// Depends on mstw_pkg.
`default_nettype none
module mstw_back #(
  parameter int MAX_VERTICES = mstw_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES = mstw_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS = mstw_pkg::WEIGHT_BITS_DEF,
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1
) (
  input  wire logic                 clk,
  input  wire logic                 rst_n,
  input  wire logic [mstw_pkg::VTX_W-1:0] vcount,
  input  wire logic                 job_valid,
  input  wire mstw_pkg::job_t       job,
  output logic                      job_pop,
  output logic [AW-1:0]             raddr,
  input  wire logic [2*mstw_pkg::VTX_W+WEIGHT_BITS-1:0] rdata,
  output logic                      out_valid,
  output mstw_pkg::out_item_t       out_item
);
  localparam int VW = mstw_pkg::VTX_W;
  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;

  state_t state_r;
  logic [MAX_VERTICES:0] tree_r;
  logic [16:0] fill_r, idx_r;
  logic        rv_r;
  logic        drop_r, found_r;
  logic [VW-1:0] n_r, reached_r, best_v_r;
  logic signed [WEIGHT_BITS-1:0] best_w_r;
  logic signed [mstw_pkg::TOTAL_W-1:0] sum_r;

  logic [VW-1:0] ea, eb, fresh, n_eff;
  logic signed [WEIGHT_BITS-1:0] ew;
  logic a_ok, b_ok, in_a, in_b, cand, take_it;

  assign ea = rdata[2*VW+WEIGHT_BITS-1 -: VW];
  assign eb = rdata[VW+WEIGHT_BITS-1 -: VW];
  assign ew = rdata[WEIGHT_BITS-1:0];
  assign a_ok = (ea != '0) && (ea <= n_r);
  assign b_ok = (eb != '0) && (eb <= n_r);
  assign in_a = a_ok && tree_r[ea];
  assign in_b = b_ok && tree_r[eb];
  assign cand = rv_r && a_ok && b_ok && (in_a != in_b);
  assign fresh = in_a ? eb : ea;
  assign take_it = cand && (!found_r || ew < best_w_r);
  assign n_eff = (vcount == '0) ? VW'(1)
               : (vcount > VW'(MAX_VERTICES)) ? VW'(MAX_VERTICES) : vcount;
  assign raddr = idx_r[AW-1:0];
  assign job_pop = (state_r == S_IDLE) && job_valid;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_valid <= 1'b0;
      rv_r      <= 1'b0;
    end else begin
      out_valid <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (job_valid) begin
            fill_r    <= job.fill;
            drop_r    <= job.dropped;
            n_r       <= n_eff;
            tree_r    <= (MAX_VERTICES+1)'(2);
            reached_r <= VW'(1);
            sum_r     <= '0;
            found_r   <= 1'b0;
            idx_r     <= '0;
            rv_r      <= 1'b0;
            state_r   <= S_DONE;
            if (n_eff > VW'(1)) state_r <= S_SCAN;
          end
        end
        S_SCAN: begin
          // issue reads idx_r, evaluate the read issued in the previous cycle
          rv_r <= idx_r < fill_r;
          if (idx_r < fill_r) idx_r <= idx_r + 17'd1;
          if (take_it) begin
            found_r  <= 1'b1;
            best_w_r <= ew;
            best_v_r <= fresh;
          end
          if (!(idx_r < fill_r) && !rv_r) begin
            // round over
            idx_r   <= '0;
            found_r <= 1'b0;
            if (!found_r) begin
              state_r <= S_DONE;
            end else begin
              tree_r[best_v_r] <= 1'b1;
              sum_r <= sum_r + mstw_pkg::TOTAL_W'(best_w_r);
              reached_r <= reached_r + VW'(1);
              if (reached_r + VW'(1) >= n_r) state_r <= S_DONE;
            end
          end
        end
        S_DONE: begin
          out_valid <= 1'b1;
          out_item.total_weight  <= sum_r;
          out_item.disconnected  <= reached_r < n_r;
          out_item.edges_dropped <= drop_r;
          state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end
endmodule
`default_nettype wire

@@ rtl/core/minimum_spanning_tree_weight.sv @@
// minimum_spanning_tree_weight: top level, edge front end, job queue, Prim back end.
// Depends on mstw_pkg, mstw_ram, mstw_front, mstw_back.
//
// Usage: write vertex_count through cfg_we/cfg_wdata while idle. Present one
// edge per cycle on in_item with start; a transfer happens when start is high
// and busy is low. Edges stream into the edge store at one per cycle while
// busy is low. The transfer with last_edge set queues a job; busy rises and
// the back end runs Prim rounds, each a pass over the stored edges, up to
// vertex_count-1 rounds. The result appears on out_item for one cycle marked
// by out_valid; the receiver cannot stall. busy stays high until the result
// has left. Reset clears fill count, overflow flag and the job queue; the
// edge store needs no clear since only written entries are read.
`default_nettype none
module minimum_spanning_tree_weight #(
  parameter int MAX_VERTICES = mstw_pkg::MAX_VERTICES_DEF,
  parameter int MAX_EDGES    = mstw_pkg::MAX_EDGES_DEF,
  parameter int WEIGHT_BITS  = mstw_pkg::WEIGHT_BITS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          start,
  output logic                               busy,
  input  wire mstw_pkg::in_item_t            in_item,
  output logic                               out_valid,
  output mstw_pkg::out_item_t                out_item,
  input  wire logic                          cfg_we,
  input  wire logic [mstw_pkg::VTX_W-1:0]    cfg_wdata
);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = 2*mstw_pkg::VTX_W + WEIGHT_BITS;

  logic [mstw_pkg::VTX_W-1:0] vcount_r;
  logic we, job_push, job_pop, take;
  logic [AW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  mstw_pkg::job_t job_in, job_q_r;
  logic q_valid_r, back_busy_r;

  // one-entry job queue; hold off new edges while a job is queued or running
  assign busy = q_valid_r || back_busy_r || out_valid;
  assign take = start && !busy;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r    <= mstw_pkg::VTX_W'(1);
      q_valid_r   <= 1'b0;
      back_busy_r <= 1'b0;
    end else begin
      if (cfg_we) vcount_r <= cfg_wdata;
      if (job_push) q_valid_r <= 1'b1;
      else if (job_pop) q_valid_r <= 1'b0;
      if (job_pop) back_busy_r <= 1'b1;
      else if (out_valid) back_busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (job_push) job_q_r <= job_in;
  end

  mstw_front #(.MAX_EDGES(MAX_EDGES), .WEIGHT_BITS(WEIGHT_BITS)) u_front (
    .clk, .rst_n, .take, .item(in_item), .we, .waddr, .wdata,
    .job_push, .job(job_in)
  );

  mstw_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_store (
    .clk, .we, .waddr, .wdata, .raddr, .rdata
  );

  mstw_back #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES),
              .WEIGHT_BITS(WEIGHT_BITS)) u_back (
    .clk, .rst_n, .vcount(vcount_r), .job_valid(q_valid_r), .job(job_q_r),
    .job_pop, .raddr, .rdata, .out_valid, .out_item
  );
endmodule
`default_nettype wire

@@ rtl/core/mstw_checker.sv @@
// mstw_checker: port-level assertions for minimum_spanning_tree_weight.
// Depends on mstw_pkg; bound to the top level below.
`default_nettype none
module mstw_checker (
  input wire logic clk,
  input wire logic rst_n,
  input wire logic start,
  input wire logic busy,
  input wire logic out_valid,
  input wire mstw_pkg::in_item_t in_item
);
  a_no_back_to_back: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid) else $error("double result strobe");
  a_busy_on_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy) else $error("result without busy");
  a_last_makes_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy && in_item.last_edge) |=> busy) else $error("busy not raised");
  a_idle_after_reset: assert property (@(posedge clk)
    (rst_n && !$past(rst_n)) |-> !out_valid) else $error("result out of reset");
endmodule

bind minimum_spanning_tree_weight mstw_checker u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .in_item
);
`default_nettype wire

@@ tb/sv/tb.sv @@
// tb: self-checking testbench for minimum_spanning_tree_weight (Prim tree weight).
// Depends on mstw_pkg and the minimum_spanning_tree_weight RTL.
`timescale 1ns / 1ps
module tb;
  localparam int MAXV = 64;
  localparam int MAXE = 256;
  localparam longint CYCLE_LIMIT = 5000000;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  mstw_pkg::in_item_t in_item = '0;
  logic out_valid;
  mstw_pkg::out_item_t out_item;
  logic cfg_we = 1'b0;
  logic [mstw_pkg::VTX_W-1:0] cfg_wdata = '0;

  minimum_spanning_tree_weight dut (
    .clk(clk), .rst_n(rst_n), .start(start), .busy(busy), .in_item(in_item),
    .out_valid(out_valid), .out_item(out_item), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // Predictor state: the graph being collected and the vertex count setting.
  logic [mstw_pkg::VTX_W-1:0] graph_from [MAXE];
  logic [mstw_pkg::VTX_W-1:0] graph_to [MAXE];
  logic signed [15:0] graph_wt [MAXE];
  int graph_fill = 0;
  bit graph_overflow = 0;
  logic [mstw_pkg::VTX_W-1:0] vcount = 1;

  mstw_pkg::out_item_t tree_results[$];
  int fail_count = 0;
  int edges_sent = 0;
  int results_seen = 0;
  longint cycles = 0;
  int idle_pct = 0;

  task automatic report_mismatch(input string what);
    $display("mismatch at cycle %0d: %s", cycles, what);
    fail_count++;
  endtask

  // Grow the tree from vertex 1 over the stored edges and queue the result.
  task automatic predict_tree();
    bit in_tree [MAXV+1];
    int n, reached, best_v, a, b, fresh;
    longint sum, best_w;
    bit found;
    mstw_pkg::out_item_t r;
    n = vcount;
    if (n < 1) n = 1;
    if (n > MAXV) n = MAXV;
    foreach (in_tree[k]) in_tree[k] = 0;
    in_tree[1] = 1;
    reached = 1;
    sum = 0;
    while (reached < n) begin
      found = 0; best_w = 0; best_v = 0;
      for (int i = 0; i < graph_fill; i++) begin
        a = graph_from[i]; b = graph_to[i];
        if (a < 1 || a > n || b < 1 || b > n) continue;
        if (in_tree[a] && !in_tree[b]) fresh = b;
        else if (in_tree[b] && !in_tree[a]) fresh = a;
        else continue;
        if (!found || graph_wt[i] < best_w) begin
          found = 1; best_w = graph_wt[i]; best_v = fresh;
        end
      end
      if (!found) break;
      in_tree[best_v] = 1;
      sum += best_w;
      reached++;
    end
    r.total_weight = sum[mstw_pkg::TOTAL_W-1:0];
    r.disconnected = (reached < n);
    r.edges_dropped = graph_overflow;
    tree_results = {tree_results, r};
    graph_fill = 0;
    graph_overflow = 0;
  endtask

  // Hold start until the transfer happens; insert random idle beforehand.
  task automatic send_edge(input int f, input int t, input int w, input bit last);
    mstw_pkg::in_item_t e;
    while ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    e.edge_from = f[mstw_pkg::VTX_W-1:0];
    e.edge_to = t[mstw_pkg::VTX_W-1:0];
    e.edge_weight = w[15:0];
    e.last_edge = last;
    start <= 1'b1;
    in_item <= e;
    @(posedge clk);
    while (busy) @(posedge clk);
    // Transfer taken at this edge: update the predictor.
    if (graph_fill < MAXE) begin
      graph_from[graph_fill] = e.edge_from;
      graph_to[graph_fill] = e.edge_to;
      graph_wt[graph_fill] = e.edge_weight;
      graph_fill++;
    end else graph_overflow = 1;
    edges_sent++;
    if (last) predict_tree();
  endtask

  // Drop start, drain outstanding results, then pause before touching the register.
  task automatic wait_idle();
    start <= 1'b0;
    while (tree_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_vcount(input int v);
    wait_idle();
    cfg_we <= 1'b1;
    cfg_wdata <= v[mstw_pkg::VTX_W-1:0];
    @(posedge clk);
    cfg_we <= 1'b0;
    vcount = v[mstw_pkg::VTX_W-1:0];
  endtask

  // Check every strobed result against the oldest prediction.
  always @(posedge clk) begin
    if (rst_n && out_valid) begin
      results_seen++;
      if (tree_results.size() == 0) report_mismatch("result with nothing expected");
      else begin
        mstw_pkg::out_item_t x;
        x = tree_results.pop_front();
        if (out_item.total_weight !== x.total_weight)
          report_mismatch($sformatf("total_weight %0d, expected %0d",
                                    out_item.total_weight, x.total_weight));
        if (out_item.disconnected !== x.disconnected)
          report_mismatch($sformatf("disconnected %0b, expected %0b",
                                    out_item.disconnected, x.disconnected));
        if (out_item.edges_dropped !== x.edges_dropped)
          report_mismatch($sformatf("edges_dropped %0b, expected %0b",
                                    out_item.edges_dropped, x.edges_dropped));
      end
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("tb: FAIL");
      $finish;
    end
  end

  // Extremes of the fields, self-loops, out-of-range vertices, disconnection.
  task automatic test_directed();
    idle_pct = 0;
    send_edge(1, 1, 5, 1);                       // single vertex, reset count
    write_vcount(0);                             // zero counts as one
    send_edge(1, 2, -32768, 1);
    write_vcount(4);
    send_edge(1, 2, 32767, 0);
    send_edge(2, 2, -100, 0);                    // self-loop
    send_edge(0, 3, -5, 0);                      // vertex zero
    send_edge(127, 4, -5, 0);                    // vertex above range
    send_edge(2, 3, -32768, 0);
    send_edge(3, 4, 7, 0);
    send_edge(4, 1, 7, 1);                       // tie
    send_edge(1, 2, 3, 1);                       // disconnected
    write_vcount(127);                           // saturates to 64
    for (int v = 1; v < 64; v++) send_edge(v, v + 1, 32767, v == 63);
    write_vcount(64);
    for (int v = 2; v <= 64; v++) send_edge(1, v, -32768, 0);
    send_edge(64, 1, -1, 1);
  endtask

  task automatic test_overflow();
    write_vcount(3);
    for (int i = 0; i < MAXE + 4; i++)
      send_edge($urandom_range(3, 1), $urandom_range(3, 1), $urandom_range(65535),
                i == MAXE + 3);
    for (int i = 0; i < MAXE; i++) send_edge(1, 2, 1, i == MAXE - 1); // exactly full
  endtask

  // Random graphs: mostly small, in-range vertices; some noise and large counts.
  task automatic test_random(input int n_edges, input int pct);
    int sent, vc, len, f, t;
    idle_pct = pct;
    sent = 0;
    while (sent < n_edges) begin
      vc = ($urandom_range(9) == 0) ? $urandom_range(64, 1) : $urandom_range(8, 1);
      if ($urandom_range(19) == 0) vc = $urandom_range(127, 65);
      write_vcount(vc);
      for (int g = 0; g < 4; g++) begin
        len = $urandom_range(2 * (vc > 64 ? 64 : vc) + 2, 1);
        if (len > 40 && $urandom_range(3) != 0) len = 40;
        for (int i = 0; i < len; i++) begin
          if ($urandom_range(9) == 0) begin
            f = $urandom_range(127); t = $urandom_range(127);
          end else begin
            f = $urandom_range(vc > 64 ? 64 : vc, 1);
            t = $urandom_range(vc > 64 ? 64 : vc, 1);
          end
          send_edge(f, t, $urandom_range(65535), i == len - 1);
        end
        sent += len;
      end
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_overflow();
    test_random(350, 0);
    test_random(300, 56);
    test_random(200, 6);
    test_random(200, 0);
    wait_idle();
    repeat (50) @(posedge clk);
    $display("covered %0d edges and %0d tree results, including a full edge store,",
             edges_sent, results_seen);
    $display("self-loops, out-of-range vertices, and vertex counts from 0 to 127");
    if (fail_count == 0) $display("tb: PASS");
    else $display("tb: FAIL");
    $finish;
  end
endmodule
